// ----- hw/rtl/dbfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfd_pkg: shared types and constants for the detection box filter decode
// Register indexes, queue entry layout, configuration bundle, class table.
// ----------------------------------------------------------------------------
package dbfd_pkg;

   localparam int NumClasses = 5;
   localparam int ClsSelW    = 3;
   localparam int QueueDepth = 4;
   localparam int QPtrW      = 2;
   localparam int QCountW    = 3;

   localparam logic [2:0] CSR_NET_WIDTH      = 3'd0;
   localparam logic [2:0] CSR_NET_HEIGHT     = 3'd1;
   localparam logic [2:0] CSR_THR_BICYCLE    = 3'd2;
   localparam logic [2:0] CSR_THR_CAR        = 3'd3;
   localparam logic [2:0] CSR_THR_MOTORCYCLE = 3'd4;
   localparam logic [2:0] CSR_THR_BUS        = 3'd5;
   localparam logic [2:0] CSR_THR_TRUCK      = 3'd6;

   localparam logic [11:0] NET_SIZE_RESET = 12'd640;
   localparam logic [15:0] THR_RESET      = 16'd16384;

   localparam logic [2:0] CLASS_BICYCLE    = 3'd1;
   localparam logic [2:0] CLASS_CAR        = 3'd2;
   localparam logic [2:0] CLASS_MOTORCYCLE = 3'd3;
   localparam logic [2:0] CLASS_BUS        = 3'd5;
   localparam logic [2:0] CLASS_TRUCK      = 3'd7;

   typedef struct packed {
      logic [11:0]                      net_width;
      logic [11:0]                      net_height;
      logic [NumClasses-1:0][15:0]      thr;
   } dbfd_cfg_type;

   typedef struct packed {
      logic signed [17:0] x_lo;
      logic signed [17:0] x_hi;
      logic signed [17:0] y_lo;
      logic signed [17:0] y_hi;
      logic [2:0]         class_id;
      logic [15:0]        confidence;
   } dbfd_entry_type;

   function automatic logic [2:0] class_of(input logic [ClsSelW-1:0] sel);
      logic [2:0] id;
      case (sel)
         3'd0:    id = CLASS_BICYCLE;
         3'd1:    id = CLASS_CAR;
         3'd2:    id = CLASS_MOTORCYCLE;
         3'd3:    id = CLASS_BUS;
         3'd4:    id = CLASS_TRUCK;
         default: id = CLASS_BICYCLE;
      endcase
      return id;
   endfunction

endpackage

// ----- hw/rtl/dbfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfd_front: box intake and classification
// Picks the best class, applies score and geometry checks, forms raw corners.
// ----------------------------------------------------------------------------
module dbfd_front (
   input  logic                   clock,
   input  logic                   reset,
   input  dbfd_pkg::dbfd_cfg_type cfg_i,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [143:0]           req_tdata,   // center_x, center_y, box_w, box_h,
                                               // score_bicycle, score_car,
                                               // score_motorcycle, score_bus, score_truck
   input  logic                   req_tuser,   // coords_finite
   input  logic                   q_full_i,
   output logic                   q_push_o,
   output dbfd_pkg::dbfd_entry_type q_data_o
);
   import dbfd_pkg::*;

   logic signed [15:0]         cx, cy, bw, bh;
   logic [NumClasses-1:0][15:0] score;
   logic [15:0]                best;
   logic [ClsSelW-1:0]         best_sel;
   logic                       found;
   logic [15:0]                thr_sel;
   logic                       keep;
   dbfd_entry_type             entry;

   logic                       valid_ff, valid_in;
   logic                       keep_ff;
   dbfd_entry_type             entry_ff;
   logic                       done;

   assign cx = req_tdata[15:0];
   assign cy = req_tdata[31:16];
   assign bw = req_tdata[47:32];
   assign bh = req_tdata[63:48];
   assign score = req_tdata[143:64];

   always_comb begin
      best     = 16'd0;
      best_sel = '0;
      found    = 1'b0;
      for (int i = 0; i < NumClasses; i++) begin
         if (score[i] > best) begin
            best     = score[i];
            best_sel = ClsSelW'(i);
            found    = 1'b1;
         end
      end
   end

   always_comb begin
      case (best_sel)
         3'd0:    thr_sel = cfg_i.thr[0];
         3'd1:    thr_sel = cfg_i.thr[1];
         3'd2:    thr_sel = cfg_i.thr[2];
         3'd3:    thr_sel = cfg_i.thr[3];
         3'd4:    thr_sel = cfg_i.thr[4];
         default: thr_sel = cfg_i.thr[0];
      endcase
   end

   assign keep = found && (best >= thr_sel) && req_tuser
                 && !bw[15] && (bw != 16'sd0) && !bh[15] && (bh != 16'sd0);

   always_comb begin
      entry.x_lo       = {cx[15], cx, 1'b0} - {{2{bw[15]}}, bw};
      entry.x_hi       = {cx[15], cx, 1'b0} + {{2{bw[15]}}, bw};
      entry.y_lo       = {cy[15], cy, 1'b0} - {{2{bh[15]}}, bh};
      entry.y_hi       = {cy[15], cy, 1'b0} + {{2{bh[15]}}, bh};
      entry.class_id   = class_of(best_sel);
      entry.confidence = best;
   end

   assign done       = valid_ff && (!keep_ff || !q_full_i);
   assign req_tready = !valid_ff || done;
   assign q_push_o   = valid_ff && keep_ff && !q_full_i;
   assign q_data_o   = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         keep_ff  <= keep;
         entry_ff <= entry;
      end
   end

endmodule

// ----- hw/rtl/dbfd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfd_queue: short queue between front and back
// Holds classified boxes so either side can stall on its own.
// ----------------------------------------------------------------------------
module dbfd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_i,
   input  dbfd_pkg::dbfd_entry_type  push_data_i,
   output logic                      full_o,
   input  logic                      pop_i,
   output logic                      valid_o,
   output dbfd_pkg::dbfd_entry_type  head_o
);
   import dbfd_pkg::*;

   dbfd_entry_type            slot_ff [QueueDepth];
   logic [QPtrW-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QCountW-1:0]        count_ff, count_in;

   assign full_o  = (count_ff == QCountW'(QueueDepth));
   assign valid_o = (count_ff != '0);
   assign head_o  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_i  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= push_data_i;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push_i && full_o))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop_i && !valid_o))
      else $error("queue pop while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_i && !pop_i) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPtrW-1:0])
      else $error("queue pointers disagree with count");

endmodule

// ----- hw/rtl/dbfd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbfd_back: clamp and result stage
// Clamps corners to the frame, drops thin boxes, holds the result register.
// ----------------------------------------------------------------------------
module dbfd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dbfd_pkg::dbfd_cfg_type   cfg_i,
   input  logic                     q_valid_i,
   input  dbfd_pkg::dbfd_entry_type q_head_i,
   output logic                     q_pop_o,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [87:0]              rsp_tdata,   // left, top, width, height, confidence
   output logic [2:0]               rsp_tuser    // class_id
);
   import dbfd_pkg::*;

   function automatic logic [16:0] clamp17(input logic signed [17:0] v,
                                           input logic [16:0] hi);
      logic [16:0] r;
      if (v[17]) begin
         r = 17'd0;
      end else if (v[16:0] > hi) begin
         r = hi;
      end else begin
         r = v[16:0];
      end
      return r;
   endfunction

   logic [16:0] hi_x, hi_y;
   logic [16:0] xa, xb, ya, yb;
   logic [16:0] span_x, span_y;
   logic        keep;

   logic        valid_ff, valid_in;
   logic [16:0] left_ff, top_ff, width_ff, height_ff;
   logic [2:0]  class_ff;
   logic [15:0] conf_ff;

   assign hi_x = {cfg_i.net_width, 5'd0};
   assign hi_y = {cfg_i.net_height, 5'd0};

   always_comb begin
      xa     = clamp17(q_head_i.x_lo, hi_x);
      xb     = clamp17(q_head_i.x_hi, hi_x);
      ya     = clamp17(q_head_i.y_lo, hi_y);
      yb     = clamp17(q_head_i.y_hi, hi_y);
      span_x = xb - xa;
      span_y = yb - ya;
      keep   = (|span_x[16:5]) && (|span_y[16:5]);
   end

   assign q_pop_o = q_valid_i && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (q_pop_o) begin
         valid_in = keep;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop_o && keep) begin
         left_ff   <= xa;
         top_ff    <= ya;
         width_ff  <= span_x;
         height_ff <= span_y;
         class_ff  <= q_head_i.class_id;
         conf_ff   <= q_head_i.confidence;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'd0, conf_ff, height_ff, width_ff, top_ff, left_ff};
   assign rsp_tuser  = class_ff;

endmodule

// ----- hw/rtl/detection_box_filter_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// detection_box_filter_decode: vehicle detection box filter and decoder
// Path: a kept box is registered at intake, queued, then held in the result register.
// Throughput: one box per cycle unless stalled; a four-entry queue decouples
// intake and the clamp stage, so either side stalls independently.
// Reset: synchronous; clears queue and valid flags, loads frame 640x640 and
// all class thresholds to 0.25.
// ----------------------------------------------------------------------------
module detection_box_filter_decode (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,   // center_x, center_y, box_w, box_h, score_bicycle,
                                     // score_car, score_motorcycle, score_bus, score_truck
   input  logic         req_tuser,   // coords_finite
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [87:0]  rsp_tdata,   // left, top, width, height, confidence, zero pad
   output logic [2:0]   rsp_tuser,   // class_id
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import dbfd_pkg::*;

   dbfd_cfg_type   cfg_ff, cfg_in;
   logic           q_push, q_full, q_pop, q_valid;
   dbfd_entry_type q_wdata, q_head;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NET_WIDTH:      cfg_in.net_width  = csr_wdata[11:0];
            CSR_NET_HEIGHT:     cfg_in.net_height = csr_wdata[11:0];
            CSR_THR_BICYCLE:    cfg_in.thr[0]     = csr_wdata;
            CSR_THR_CAR:        cfg_in.thr[1]     = csr_wdata;
            CSR_THR_MOTORCYCLE: cfg_in.thr[2]     = csr_wdata;
            CSR_THR_BUS:        cfg_in.thr[3]     = csr_wdata;
            CSR_THR_TRUCK:      cfg_in.thr[4]     = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.net_width  <= NET_SIZE_RESET;
         cfg_ff.net_height <= NET_SIZE_RESET;
         for (int i = 0; i < NumClasses; i++) begin
            cfg_ff.thr[i] <= THR_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dbfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full_i   (q_full),
      .q_push_o   (q_push),
      .q_data_o   (q_wdata)
   );

   dbfd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_i      (q_push),
      .push_data_i (q_wdata),
      .full_o      (q_full),
      .pop_i       (q_pop),
      .valid_o     (q_valid),
      .head_o      (q_head)
   );

   dbfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_i      (cfg_ff),
      .q_valid_i  (q_valid),
      .q_head_i   (q_head),
      .q_pop_o    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
